### rtl/core/alt_pkg.sv
// Shared types, constants and character/keyword helpers for the assembly line tokenizer.
package alt_pkg;

    localparam int LINE_MAX    = 256;
    localparam int TOKEN_LIMIT = 64;
    localparam int COL_W       = $clog2(LINE_MAX + 1);
    localparam int CNT_W       = $clog2(TOKEN_LIMIT + 1);
    localparam int HEAD_N      = 5;
    localparam int OUTQ_DEPTH  = 4;   // power of two, at least 2
    localparam int PTR_W       = $clog2(OUTQ_DEPTH);
    localparam int OCNT_W      = $clog2(OUTQ_DEPTH + 1);
    localparam int KW_N        = 17;

    localparam logic [4:0] KIND_EQ     = 5'd0;
    localparam logic [4:0] KIND_RBRACK = 5'd1;
    localparam logic [4:0] KIND_LBRACK = 5'd2;
    localparam logic [4:0] KIND_AT     = 5'd3;
    localparam logic [4:0] KIND_DOLLAR = 5'd4;
    localparam logic [4:0] KIND_COMMA  = 5'd5;
    localparam logic [4:0] KIND_LABEL  = 5'd22;
    localparam logic [4:0] KIND_REG    = 5'd23;
    localparam logic [4:0] KIND_NUM    = 5'd24;
    localparam logic [4:0] KIND_EOL    = 5'd26;
    localparam logic [4:0] KIND_ERR    = 5'd27;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_BAD_CHAR = 2'd1;
    localparam logic [1:0] ERR_TOO_MANY = 2'd2;
    localparam logic [1:0] ERR_TOO_LONG = 2'd3;

    localparam logic [7:0] CH_NUL    = 8'd0;
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_SEMI   = 8'd59;
    localparam logic [7:0] CH_EQ     = 8'd61;
    localparam logic [7:0] CH_RBRACK = 8'd93;
    localparam logic [7:0] CH_LBRACK = 8'd91;
    localparam logic [7:0] CH_AT     = 8'd64;
    localparam logic [7:0] CH_DOLLAR = 8'd36;
    localparam logic [7:0] CH_COMMA  = 8'd44;
    localparam logic [7:0] CH_UNDER  = 8'd95;
    localparam logic [7:0] CH_R      = 8'd82;

    // keyword text, left aligned and space padded to five characters
    localparam logic [39:0] KW_TXT [KW_N] = '{
        "LOAD ", "STORE", "READ ", "WRITE", "ADD  ", "SUB  ", "MUL  ", "DIV  ",
        "INC  ", "BR   ", "BLT  ", "BGT  ", "BLEQ ", "BGEQ ", "BEQ  ", "BNEQ ", "HALT "
    };
    localparam logic [2:0] KW_LEN [KW_N] = '{
        3'd4, 3'd5, 3'd4, 3'd5, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd3, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd3, 3'd4, 3'd4
    };
    // leading characters that must match exactly in uppercase
    localparam logic [2:0] KW_EXACT [KW_N] = '{
        3'd1, 3'd2, 3'd1, 3'd1, 3'd1, 3'd2, 3'd1, 3'd1,
        3'd1, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd2, 3'd2, 3'd1
    };
    localparam logic [4:0] KW_KIND [KW_N] = '{
        5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13,
        5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21, 5'd25
    };

    typedef enum logic [3:0] {
        MODE_IDLE  = 4'b0001,
        MODE_NUM   = 4'b0010,
        MODE_IDENT = 4'b0100,
        MODE_SKIP  = 4'b1000
    } mode_t;

    typedef struct packed {
        logic [4:0] kind;
        logic [7:0] start_col;
        logic [8:0] tok_len;
        logic [6:0] token_total;
        logic [7:0] bad_char;
        logic [1:0] err_code;
        logic       run_last;
    } res_t;

    // up to two results from one character, r0 first
    typedef struct packed {
        logic [1:0] n;
        res_t       r0;
        res_t       r1;
    } push_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

    function automatic logic [7:0] fold_up(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) ? c - 8'd32 : c;
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c == CH_EQ) || (c == CH_RBRACK) || (c == CH_LBRACK) ||
               (c == CH_AT) || (c == CH_DOLLAR) || (c == CH_COMMA);
    endfunction

    function automatic logic [4:0] punct_kind(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            CH_EQ:     k = KIND_EQ;
            CH_RBRACK: k = KIND_RBRACK;
            CH_LBRACK: k = KIND_LBRACK;
            CH_AT:     k = KIND_AT;
            CH_DOLLAR: k = KIND_DOLLAR;
            default:   k = KIND_COMMA;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] ident_kind(input logic [COL_W-1:0] run,
                                               input logic [HEAD_N-1:0][7:0] hd);
        logic [4:0] k;
        logic       ok;
        logic [7:0] p;
        k = KIND_LABEL;
        // walk backwards so the first table entry that matches wins
        for (int e = KW_N - 1; e >= 0; e--) begin
            ok = (run == COL_W'(KW_LEN[e]));
            for (int i = 0; i < HEAD_N; i++) begin
                p = KW_TXT[e][39 - 8*i -: 8];
                if (i < int'(KW_LEN[e])) begin
                    if (i < int'(KW_EXACT[e]))
                        ok = ok && (hd[i] == p);
                    else
                        ok = ok && (fold_up(hd[i]) == p);
                end
            end
            if (ok)
                k = KW_KIND[e];
        end
        if ((run == COL_W'(2)) && (hd[0] == CH_R) && is_digit(hd[1]))
            k = KIND_REG;
        return k;
    endfunction

    function automatic res_t mk_res(input logic [4:0] kind, input logic [7:0] start,
                                    input logic [8:0] len, input logic [6:0] total,
                                    input logic [7:0] bad, input logic [1:0] err);
        res_t r;
        r.kind        = kind;
        r.start_col   = start;
        r.tok_len     = len;
        r.token_total = total;
        r.bad_char    = bad;
        r.err_code    = err;
        r.run_last    = 1'b0;
        return r;
    endfunction

endpackage

### rtl/core/assembly_line_tokenizer.sv
// Assembly line tokenizer: one source character in, token, line-end and error results out.
// One character is taken per cycle while in_stall is low. A character is held in an input
// register and scanned from there, which updates the line state and writes zero, one or
// two results into a four-entry result queue; its results pass from the input register
// through the result queue to the output. The output side delivers one result per cycle
// while out_stall is low. A character that closes a token and is itself a token or error
// yields two results; a waiting character stalls the input whenever the queue has fewer
// than two free entries.
module assembly_line_tokenizer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_code,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [4:0] kind,
    output logic [7:0] start_col,
    output logic [8:0] tok_len,
    output logic [6:0] token_total,
    output logic [7:0] bad_char,
    output logic [1:0] err_code,
    output logic       run_last
);
    import alt_pkg::*;

    push_t push;
    logic  room;
    res_t  head;

    alt_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_code (char_code),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .room      (room),
        .push      (push)
    );

    alt_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign kind        = head.kind;
    assign start_col   = head.start_col;
    assign tok_len     = head.tok_len;
    assign token_total = head.token_total;
    assign bad_char    = head.bad_char;
    assign err_code    = head.err_code;
    assign run_last    = head.run_last;

endmodule

### rtl/core/alt_scan.sv
// Input register and per-character scanner: line state and up to two results per character.
module alt_scan (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    char_code,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic          room,
    output alt_pkg::push_t push
);
    import alt_pkg::*;

    logic                      in_valid_reg;
    logic [7:0]                char_reg;
    mode_t                     mode_reg, mode_next;
    logic [COL_W-1:0]          column_reg, column_next;
    logic [7:0]                tok_start_reg, tok_start_next;
    logic [COL_W-1:0]          run_reg, run_next;
    logic [HEAD_N-1:0][7:0]    heads_reg, heads_next;
    logic [CNT_W-1:0]          line_tokens_reg, line_tokens_next;

    logic             proc;
    logic             term;
    logic             pending;
    logic             over;
    logic             col_over;
    logic             cont;
    logic [CNT_W-1:0] lt1;
    logic [COL_W-1:0] col_inc;
    logic [7:0]       col8;
    res_t             flush_res;
    res_t             sec_res;
    logic             have_flush;
    logic             have_sec;
    res_t             r0;
    res_t             r1;

    assign proc     = in_valid_reg && room;
    assign in_stall = in_valid_reg && !room;

    assign term     = (char_reg == CH_NUL) || (char_reg == CH_LF);
    assign pending  = (mode_reg == MODE_NUM) || (mode_reg == MODE_IDENT);
    assign over     = line_tokens_reg >= CNT_W'(TOKEN_LIMIT);
    assign col_over = column_reg >= COL_W'(LINE_MAX);
    assign cont     = ((mode_reg == MODE_IDENT) &&
                       (is_alpha(char_reg) || is_digit(char_reg) || (char_reg == CH_UNDER))) ||
                      ((mode_reg == MODE_NUM) && is_digit(char_reg));
    assign lt1      = line_tokens_reg + CNT_W'(pending && !over);
    assign col_inc  = col_over ? column_reg : column_reg + 1'b1;
    assign col8     = column_reg[7:0];

    always_comb
    begin
        if (over)
            flush_res = mk_res(KIND_ERR, tok_start_reg, 9'(run_reg), 7'd0, 8'd0, ERR_TOO_MANY);
        else if (mode_reg == MODE_NUM)
            flush_res = mk_res(KIND_NUM, tok_start_reg, 9'(run_reg), 7'd0, 8'd0, ERR_NONE);
        else
            flush_res = mk_res(ident_kind(run_reg, heads_reg), tok_start_reg, 9'(run_reg),
                               7'd0, 8'd0, ERR_NONE);
    end

    always_comb
    begin
        mode_next        = mode_reg;
        column_next      = column_reg;
        tok_start_next   = tok_start_reg;
        run_next         = run_reg;
        heads_next       = heads_reg;
        line_tokens_next = line_tokens_reg;
        have_flush       = 1'b0;
        have_sec         = 1'b0;
        sec_res          = '0;

        if (term)
        begin
            have_flush       = pending;
            have_sec         = 1'b1;
            sec_res          = mk_res(KIND_EOL, col8, 9'd0, 7'(lt1), 8'd0, ERR_NONE);
            mode_next        = MODE_IDLE;
            column_next      = '0;
            tok_start_next   = '0;
            run_next         = '0;
            heads_next       = '0;
            line_tokens_next = '0;
        end
        else if (mode_reg == MODE_SKIP)
        begin
            column_next = col_inc;
        end
        else if (col_over)
        begin
            // column holds at its limit; pending token goes out before the error
            have_flush       = pending;
            have_sec         = !pending || !over;
            sec_res          = mk_res(KIND_ERR, col8, 9'd0, 7'd0, 8'd0, ERR_TOO_LONG);
            mode_next        = MODE_SKIP;
            line_tokens_next = lt1;
        end
        else if (cont)
        begin
            if (run_reg < COL_W'(HEAD_N))
                heads_next[run_reg[2:0]] = char_reg;
            run_next    = run_reg + 1'b1;
            column_next = col_inc;
        end
        else
        begin
            column_next = col_inc;
            have_flush  = pending;
            if (pending && over)
            begin
                mode_next = MODE_SKIP;
            end
            else
            begin
                line_tokens_next = lt1;
                mode_next        = MODE_IDLE;
                if ((char_reg == CH_SPACE) || (char_reg == CH_TAB) || (char_reg == CH_CR))
                begin
                    mode_next = MODE_IDLE;
                end
                else if (char_reg == CH_SEMI)
                begin
                    mode_next = MODE_SKIP;
                end
                else if (is_punct(char_reg))
                begin
                    have_sec = 1'b1;
                    if (lt1 >= CNT_W'(TOKEN_LIMIT))
                    begin
                        sec_res   = mk_res(KIND_ERR, col8, 9'd1, 7'd0, 8'd0, ERR_TOO_MANY);
                        mode_next = MODE_SKIP;
                    end
                    else
                    begin
                        sec_res = mk_res(punct_kind(char_reg), col8, 9'd1, 7'd0, 8'd0,
                                         ERR_NONE);
                        line_tokens_next = lt1 + 1'b1;
                    end
                end
                else if (is_digit(char_reg) || is_alpha(char_reg))
                begin
                    mode_next      = is_digit(char_reg) ? MODE_NUM : MODE_IDENT;
                    tok_start_next = col8;
                    run_next       = COL_W'(1);
                    heads_next[0]  = char_reg;
                end
                else
                begin
                    have_sec  = 1'b1;
                    sec_res   = mk_res(KIND_ERR, col8, 9'd1, 7'd0, char_reg, ERR_BAD_CHAR);
                    mode_next = MODE_SKIP;
                end
            end
        end
    end

    always_comb
    begin
        r0 = have_flush ? flush_res : sec_res;
        r1 = sec_res;
        if (have_flush && have_sec)
            r1.run_last = 1'b1;
        else
            r0.run_last = 1'b1;
        push.n  = proc ? 2'(have_flush) + 2'(have_sec) : 2'd0;
        push.r0 = r0;
        push.r1 = r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (proc)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            char_reg <= char_code;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_IDLE;
            column_reg      <= '0;
            tok_start_reg   <= '0;
            run_reg         <= '0;
            heads_reg       <= '0;
            line_tokens_reg <= '0;
        end
        else if (proc)
        begin
            mode_reg        <= mode_next;
            column_reg      <= column_next;
            tok_start_reg   <= tok_start_next;
            run_reg         <= run_next;
            heads_reg       <= heads_next;
            line_tokens_reg <= line_tokens_next;
        end
    end

    a_tok_limit: assert property (@(posedge clk) disable iff (!rst_n)
        line_tokens_reg <= CNT_W'(TOKEN_LIMIT))
        else $error("line token count past limit");

    a_col_limit: assert property (@(posedge clk) disable iff (!rst_n)
        column_reg <= COL_W'(LINE_MAX))
        else $error("column past line limit");

    a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
        proc && term |=> (mode_reg == MODE_IDLE) && (column_reg == '0) &&
                         (line_tokens_reg == '0))
        else $error("line state not cleared after line end");

    a_skip_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        proc && (mode_reg == MODE_SKIP) && !term |-> push.n == 2'd0)
        else $error("result produced while skipping rest of line");

endmodule

### rtl/core/alt_outq.sv
// Result queue: takes up to two results per cycle, hands out one per request.
module alt_outq (
    input  logic           clk,
    input  logic           rst_n,
    input  alt_pkg::push_t push,
    output logic           room,
    output logic           out_valid,
    input  logic           out_stall,
    output alt_pkg::res_t  head
);
    import alt_pkg::*;

    res_t              mem [OUTQ_DEPTH];
    logic [PTR_W-1:0]  wp_reg;
    logic [PTR_W-1:0]  rp_reg;
    logic [OCNT_W-1:0] count_reg;
    logic              pop;

    assign out_valid = count_reg != '0;
    assign pop       = out_valid && !out_stall;
    assign room      = count_reg <= OCNT_W'(OUTQ_DEPTH - 2);
    assign head      = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
            mem[wp_reg] <= push.r0;
        if (push.n == 2'd2)
            mem[wp_reg + 1'b1] <= push.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wp_reg    <= wp_reg + PTR_W'(push.n);
            rp_reg    <= rp_reg + PTR_W'(pop);
            count_reg <= count_reg + OCNT_W'(push.n) - OCNT_W'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.n != 2'd0 |-> count_reg <= OCNT_W'(OUTQ_DEPTH - 2))
        else $error("request written into full result queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= OCNT_W'(OUTQ_DEPTH))
        else $error("result queue count out of range");

endmodule
